// ===== rtl/core/uer_pkg.sv =====
package uer_pkg;

    // field widths fixed by the interface
    localparam int TRIG_W      = 8;
    localparam int WIN_W       = 16;
    localparam int WRAP_W      = 16;
    localparam int DIST_W      = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // default width of the echo width counter
    localparam int COUNT_WIDTH_DEF = 16;

    // largest distance that fits the result field
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // register reset values
    localparam logic [TRIG_W-1:0] TRIG_TICKS_RST   = 8'd3;
    localparam logic [WIN_W-1:0]  WINDOW_TICKS_RST = 16'd3000;
    localparam logic [WRAP_W-1:0] WRAP_TICKS_RST   = 16'd60000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIG_TICKS   = 2'd0,
        REG_WINDOW_TICKS = 2'd1,
        REG_WRAP_TICKS   = 2'd2
    } uer_reg_t;

    // measurement sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2
    } uer_phase_t;

    // configuration seen by the ranging core
    typedef struct packed {
        logic [TRIG_W-1:0] trig_ticks;
        logic [WIN_W-1:0]  window_ticks;
        logic [WRAP_W-1:0] wrap_ticks;
    } uer_cfg_t;

    // one result item
    typedef struct packed {
        logic              trigger;
        logic              done_res;
        logic [DIST_W-1:0] distance;
        logic              timed_out;
    } uer_result_t;

endpackage

// ===== rtl/core/uer_core.sv =====
module uer_core #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic                 start_req,
    input  logic                 echo,
    input  uer_pkg::uer_cfg_t    cfg,
    output uer_pkg::uer_result_t result
);

    localparam int CMP_W  = (COUNT_WIDTH > uer_pkg::WRAP_W) ? COUNT_WIDTH : uer_pkg::WRAP_W;
    localparam int PROD_W = COUNT_WIDTH + 5;
    localparam int EXT_W  = (PROD_W > uer_pkg::DIST_W) ? PROD_W : uer_pkg::DIST_W;

    uer_pkg::uer_phase_t             phase_reg, phase_next, phase_a;
    logic                            echo_high_reg, echo_high_next;
    logic                            ready_reg, ready_next, ready_a, ready_b;
    logic                            prev_echo_reg;
    logic [COUNT_WIDTH-1:0]          width_reg, width_next;
    logic [COUNT_WIDTH-1:0]          latched_reg, latched_next;
    logic [uer_pkg::TRIG_W-1:0]      trig_count_reg, trig_count_next, trig_a, trig_dec;
    logic [uer_pkg::WIN_W-1:0]       window_reg, window_next, window_a, window_inc;
    logic                            wrap_hit;
    logic [COUNT_WIDTH-1:0]          width_inc;
    logic [PROD_W-1:0]               prod;
    logic [EXT_W-1:0]                prod_ext;
    logic [uer_pkg::DIST_W-1:0]      dist_sat;

    // start request reloads the sequencer
    always_comb
    begin
        ready_a  = start_req ? 1'b0 : ready_reg;
        phase_a  = start_req ? uer_pkg::PH_TRIG : phase_reg;
        window_a = start_req ? '0 : window_reg;
        if (start_req)
            trig_a = (cfg.trig_ticks == '0) ? uer_pkg::TRIG_W'(1) : cfg.trig_ticks;
        else
            trig_a = trig_count_reg;
    end

    // width counter increment with wrap
    assign wrap_hit  = (CMP_W'(width_reg) >= CMP_W'(cfg.wrap_ticks)) || (&width_reg);
    assign width_inc = wrap_hit ? '0 : width_reg + COUNT_WIDTH'(1);

    // echo edge tracking, frozen while a result is pending
    always_comb
    begin
        echo_high_next = echo_high_reg;
        width_next     = width_reg;
        latched_next   = latched_reg;
        ready_b        = ready_a;
        if (!ready_a)
        begin
            if (!echo_high_reg)
            begin
                if (echo && !prev_echo_reg)
                begin
                    width_next     = '0;
                    echo_high_next = 1'b1;
                end
            end
            else if (!echo && prev_echo_reg)
            begin
                latched_next   = width_inc;
                echo_high_next = 1'b0;
                ready_b        = 1'b1;
            end
            else
            begin
                width_next = width_inc;
            end
        end
    end

    // distance is count times 17, saturated to the field
    assign prod     = (PROD_W'(latched_next) << 4) + PROD_W'(latched_next);
    assign prod_ext = EXT_W'(prod);
    assign dist_sat = (prod_ext > EXT_W'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                             : prod_ext[uer_pkg::DIST_W-1:0];

    assign trig_dec   = trig_a - uer_pkg::TRIG_W'(1);
    assign window_inc = window_a + uer_pkg::WIN_W'(1);

    // phase next state
    always_comb
    begin
        phase_next = phase_a;
        case (phase_a)
            uer_pkg::PH_TRIG:
            begin
                if (trig_dec == '0)
                    phase_next = uer_pkg::PH_WAIT;
            end
            uer_pkg::PH_WAIT:
            begin
                if (ready_b || (window_inc >= cfg.window_ticks))
                    phase_next = uer_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
            end
        endcase
    end

    // phase outputs and counters
    always_comb
    begin
        result          = '0;
        ready_next      = ready_b;
        trig_count_next = trig_a;
        window_next     = window_a;
        case (phase_a)
            uer_pkg::PH_TRIG:
            begin
                result.trigger  = 1'b1;
                trig_count_next = trig_dec;
                if (trig_dec == '0)
                    window_next = '0;
            end
            uer_pkg::PH_WAIT:
            begin
                if (ready_b)
                begin
                    result.done_res = 1'b1;
                    result.distance = dist_sat;
                    ready_next      = 1'b0;
                end
                else
                begin
                    window_next = window_inc;
                    if (window_inc >= cfg.window_ticks)
                    begin
                        result.done_res  = 1'b1;
                        result.timed_out = 1'b1;
                    end
                end
            end
            default:
            begin
                ready_next = ready_b;
            end
        endcase
    end

    // state registers advance once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= uer_pkg::PH_IDLE;
            echo_high_reg  <= 1'b0;
            ready_reg      <= 1'b0;
            prev_echo_reg  <= 1'b0;
            width_reg      <= '0;
            latched_reg    <= '0;
            trig_count_reg <= '0;
            window_reg     <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            echo_high_reg  <= echo_high_next;
            ready_reg      <= ready_next;
            prev_echo_reg  <= echo;
            width_reg      <= width_next;
            latched_reg    <= latched_next;
            trig_count_reg <= trig_count_next;
            window_reg     <= window_next;
        end
    end

endmodule

// ===== rtl/core/ultrasonic_echo_ranger.sv =====
// Echo-pulse ranger driven by a 10 us time base.
// Input channel (in_valid/in_stall): one transaction per tick carries start_req
// and the sampled echo level. Output channel (out_valid/out_stall): exactly one
// transaction per input tick, carrying the trigger level to drive, done_res,
// distance_centi_cm (echo width times 17, in hundredths of a cm) and timed_out.
// distance_centi_cm and timed_out are zero whenever done_res is low.
// Configuration channel (cfg_valid/cfg_ready): cfg_index 0 trig_ticks,
// 1 window_ticks, 2 wrap_ticks; other indexes are dropped. cfg_ready is always
// high; write only while no tick is in flight.
// Throughput is one tick per cycle while in_stall is low: the whole tick update
// is a single pass through the ranging core from its state registers to the
// output buffer.
// A two-entry output buffer (result register plus skid register) lets the
// input take a transaction while a result waits; in_stall rises once both
// entries are full and drops once one drains.
// Reset clears the ranging core state, empties the output buffer (its payload
// registers keep their data) and loads the register defaults (3, 3000, 60000).
module ultrasonic_echo_ranger #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            start_req,
    input  logic                            echo,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            trigger,
    output logic                            done_res,
    output logic [uer_pkg::DIST_W-1:0]      distance_centi_cm,
    output logic                            timed_out,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data
);

    uer_pkg::uer_cfg_t    cfg_reg;
    uer_pkg::uer_result_t step_res;
    uer_pkg::uer_result_t out_reg;
    uer_pkg::uer_result_t skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic                 in_fire;
    logic                 out_fire;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trig_ticks   <= uer_pkg::TRIG_TICKS_RST;
            cfg_reg.window_ticks <= uer_pkg::WINDOW_TICKS_RST;
            cfg_reg.wrap_ticks   <= uer_pkg::WRAP_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                uer_pkg::REG_TRIG_TICKS:
                    cfg_reg.trig_ticks <= cfg_data[uer_pkg::TRIG_W-1:0];
                uer_pkg::REG_WINDOW_TICKS:
                    cfg_reg.window_ticks <= cfg_data[uer_pkg::WIN_W-1:0];
                uer_pkg::REG_WRAP_TICKS:
                    cfg_reg.wrap_ticks <= cfg_data[uer_pkg::WRAP_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // handshake decode
    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    // ranging core, one tick per transaction
    uer_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (in_fire),
        .start_req (start_req),
        .echo      (echo),
        .cfg       (cfg_reg),
        .result    (step_res)
    );

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (out_valid_reg && out_stall)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (out_valid_reg && out_stall)
                skid_reg <= step_res;
            else
                out_reg <= step_res;
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign trigger           = out_reg.trigger;
    assign done_res          = out_reg.done_res;
    assign distance_centi_cm = out_reg.distance;
    assign timed_out         = out_reg.timed_out;

    // skid entry only holds data behind a full result register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty result register");

    // skid fills only when the receiver stalled a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled without a stalled result");

    // a timeout is always a report
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.timed_out) |-> (out_reg.done_res && !out_reg.trigger))
        else $error("timeout flagged outside a report");

    // no report means empty result fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.done_res) |-> (out_reg.distance == '0 && !out_reg.timed_out))
        else $error("result fields set without a report");

endmodule

// ===== tb/ultrasonic_echo_ranger_tb.sv =====
module ultrasonic_echo_ranger_tb;

    // index with no register behind it, writes to it are dropped
    localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // quiet cycles tolerated before the run is declared hung
    localparam int QUIET_LIMIT = 1000;
    // cycles to let pass after the last result before a register write
    localparam int SETTLE_CYCLES = 4;
    // receiver hold-off used to fill the output buffer
    localparam int HOLD_CYCLES = 80;

    // directed ticks, {start_req, echo} pairs, first tick in the top bits
    localparam int DIRECTED_LEN = 22;
    localparam logic [2*DIRECTED_LEN-1:0] DIRECTED =
        44'b00_01_01_00_01_00_10_01_01_01_00_11_01_11_10_00_00_00_00_11_10_00;

    typedef struct packed {
        logic start;
        logic echo;
    } tick_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           start_req = 1'b0;
    logic                           echo = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           trigger;
    logic                           done_res;
    logic [uer_pkg::DIST_W-1:0]     distance_centi_cm;
    logic                           timed_out;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [uer_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // stimulus and expected results
    tick_t                tick_queue[$];
    uer_pkg::uer_result_t echo_results[$];
    int                   ticks_owed = 0;
    int                   ticks_added = 0;
    int                   mismatches = 0;
    int                   idle_pct = 30;
    logic                 hold_kick = 1'b0;
    int                   quiet = 0;

    // shadow configuration
    logic [uer_pkg::TRIG_W-1:0] cfg_trig = uer_pkg::TRIG_TICKS_RST;
    logic [uer_pkg::WIN_W-1:0]  cfg_window = uer_pkg::WINDOW_TICKS_RST;
    logic [uer_pkg::WRAP_W-1:0] cfg_wrap = uer_pkg::WRAP_TICKS_RST;

    // shadow ranging state
    uer_pkg::uer_phase_t                 m_phase = uer_pkg::PH_IDLE;
    logic                                m_echo_high = 1'b0;
    logic                                m_ready = 1'b0;
    logic                                m_prev_echo = 1'b0;
    logic [uer_pkg::COUNT_WIDTH_DEF-1:0] m_width = '0;
    logic [uer_pkg::COUNT_WIDTH_DEF-1:0] m_latched = '0;
    logic [uer_pkg::TRIG_W-1:0]          m_trig_cnt = '0;
    logic [uer_pkg::WIN_W-1:0]           m_win_cnt = '0;

    ultrasonic_echo_ranger u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .start_req         (start_req),
        .echo              (echo),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .trigger           (trigger),
        .done_res          (done_res),
        .distance_centi_cm (distance_centi_cm),
        .timed_out         (timed_out),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // width counter advance, restarts at zero past the wrap value or its own top
    function automatic logic [uer_pkg::COUNT_WIDTH_DEF-1:0] width_next(
        input logic [uer_pkg::COUNT_WIDTH_DEF-1:0] c);
        if (c >= cfg_wrap || c == '1)
            return '0;
        return c + 1'b1;
    endfunction

    // one tick of the ranger: start, echo edges, then trigger and wait phases
    function automatic uer_pkg::uer_result_t ranger_tick(input logic start,
                                                         input logic echo_in);
        uer_pkg::uer_result_t r;
        logic [31:0] prod;
        r = '0;
        if (start)
        begin
            m_ready = 1'b0;
            m_trig_cnt = (cfg_trig == '0) ? 8'd1 : cfg_trig;
            m_phase = uer_pkg::PH_TRIG;
            m_win_cnt = '0;
        end
        // edges are ignored while a result is ready
        if (!m_ready)
        begin
            if (!m_echo_high)
            begin
                if (echo_in && !m_prev_echo)
                begin
                    m_width = '0;
                    m_echo_high = 1'b1;
                end
            end
            else if (!echo_in && m_prev_echo)
            begin
                m_latched = width_next(m_width);
                m_echo_high = 1'b0;
                m_ready = 1'b1;
            end
            else
                m_width = width_next(m_width);
        end
        m_prev_echo = echo_in;
        case (m_phase)
            uer_pkg::PH_TRIG:
            begin
                r.trigger = 1'b1;
                m_trig_cnt = m_trig_cnt - 1'b1;
                if (m_trig_cnt == '0)
                begin
                    m_phase = uer_pkg::PH_WAIT;
                    m_win_cnt = '0;
                end
            end
            uer_pkg::PH_WAIT:
            begin
                if (m_ready)
                begin
                    prod = 32'(m_latched) * 32'd17;
                    r.distance = (prod > 32'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                                 : prod[uer_pkg::DIST_W-1:0];
                    r.done_res = 1'b1;
                    m_ready = 1'b0;
                    m_phase = uer_pkg::PH_IDLE;
                end
                else
                begin
                    m_win_cnt = m_win_cnt + 1'b1;
                    if (m_win_cnt >= cfg_window)
                    begin
                        r.done_res = 1'b1;
                        r.timed_out = 1'b1;
                        m_phase = uer_pkg::PH_IDLE;
                    end
                end
            end
            default:
                m_phase = uer_pkg::PH_IDLE;
        endcase
        return r;
    endfunction

    // driver: offers queued ticks, predicts each accepted transaction
    always @(posedge clk)
    begin : driver
        tick_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                echo_results.push_back(ranger_tick(start_req, echo));
            if (!in_valid || !in_stall)
            begin
                if (tick_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    nxt = tick_queue.pop_front();
                    in_valid <= 1'b1;
                    start_req <= nxt.start;
                    echo <= nxt.echo;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic note_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // monitor: checks each accepted result and drives the receiver stall
    always @(posedge clk)
    begin : monitor
        uer_pkg::uer_result_t want;
        int                   hold_left;
        logic                 hold_done;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (ticks_owed > 0)
                    ticks_owed--;
                if (echo_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result, expected none actual done_res %0d",
                             $time, done_res);
                end
                else
                begin
                    want = echo_results.pop_front();
                    note_field("trigger", int'(want.trigger), int'(trigger));
                    note_field("done_res", int'(want.done_res), int'(done_res));
                    note_field("distance_centi_cm", int'(want.distance),
                               int'(distance_centi_cm));
                    note_field("timed_out", int'(want.timed_out), int'(timed_out));
                end
            end
            // long hold-off once, so the input side backs up
            if (hold_kick && hold_done !== 1'b1)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
        else
            hold_left = 0;
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic add_tick(input logic s, input logic e);
        tick_queue.push_back('{start: s, echo: e});
        ticks_owed++;
        ticks_added++;
    endtask

    // mostly complete measurements, some cut short, some noise
    task automatic run_random(input int target, input int max_lead, input int max_high,
                              input int max_tail);
        int stop_at;
        int pick;
        stop_at = ticks_added + target;
        while (ticks_added < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                add_tick(1'b1, 1'b0);
                repeat ($urandom_range(0, max_lead)) add_tick(1'b0, 1'b0);
                repeat ($urandom_range(0, max_high)) add_tick(1'b0, 1'b1);
                repeat ($urandom_range(1, max_tail)) add_tick(1'b0, 1'b0);
            end
            else if (pick < 87)
            begin
                add_tick(1'b1, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, max_high)) add_tick(1'b0, 1'b1);
            end
            else
                repeat ($urandom_range(1, 6))
                    add_tick($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)));
        end
    endtask

    // wait for every result, then let the block go quiet
    task automatic settle();
        while (ticks_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uer_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            uer_pkg::REG_TRIG_TICKS:   cfg_trig = data[uer_pkg::TRIG_W-1:0];
            uer_pkg::REG_WINDOW_TICKS: cfg_window = data[uer_pkg::WIN_W-1:0];
            uer_pkg::REG_WRAP_TICKS:   cfg_wrap = data[uer_pkg::WRAP_W-1:0];
            default:                   ;
        endcase
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: late echo while idle, edges while ready, restarts
        for (int i = DIRECTED_LEN - 1; i >= 0; i--)
            add_tick(DIRECTED[2*i+1], DIRECTED[2*i]);
        run_random(200, 6, 40, 5);
        settle();

        // shortest trigger, widest counter, short window, no idling
        write_reg(uer_pkg::REG_TRIG_TICKS, 16'd1);
        write_reg(uer_pkg::REG_WINDOW_TICKS, 16'd20);
        write_reg(uer_pkg::REG_WRAP_TICKS, 16'hFFFF);
        idle_pct = 0;
        run_random(250, 25, 40, 25);
        settle();

        // longest trigger and window, counter wraps often
        idle_pct = 30;
        write_reg(uer_pkg::REG_TRIG_TICKS, 16'd255);
        write_reg(uer_pkg::REG_WINDOW_TICKS, 16'hFFFF);
        write_reg(uer_pkg::REG_WRAP_TICKS, 16'd7);
        run_random(300, 270, 20, 4);
        settle();

        // zero trigger length, zero window, counter wraps after reaching one
        write_reg(uer_pkg::REG_TRIG_TICKS, 16'd0);
        write_reg(uer_pkg::REG_WINDOW_TICKS, 16'd0);
        write_reg(uer_pkg::REG_WRAP_TICKS, 16'd1);
        write_reg(REG_SPARE, 16'h0000);
        run_random(220, 3, 6, 3);
        settle();

        // random settings, upper byte of the trigger write ignored
        write_reg(uer_pkg::REG_TRIG_TICKS,
                  {8'($urandom_range(0, 255)), 8'($urandom_range(1, 8))});
        write_reg(uer_pkg::REG_WINDOW_TICKS, 16'($urandom_range(5, 60)));
        write_reg(uer_pkg::REG_WRAP_TICKS, 16'($urandom_range(3, 40)));
        write_reg(REG_SPARE, 16'hFFFF);
        hold_kick <= 1'b1;
        run_random(300, 12, 50, 30);
        settle();

        if (echo_results.size() != 0)
        begin
            mismatches++;
            $display("%0t %0d expected results never arrived", $time, echo_results.size());
        end
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/uer_pkg.sv
rtl/core/uer_core.sv
rtl/core/ultrasonic_echo_ranger.sv
tb/ultrasonic_echo_ranger_tb.sv
